// ===== src/omni_three_wheel_odometry_assert.svh =====
// Assertion macros for the omni odometry block.
// Included by the RTL files that carry concurrent checks; no other dependency.
`ifndef OMNI_THREE_WHEEL_ODOMETRY_ASSERT_SVH
`define OMNI_THREE_WHEEL_ODOMETRY_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define OTWO_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define OTWO_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define OTWO_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define OTWO_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== src/otwo_pkg.sv =====
// Shared types, constants and helper functions of the omni odometry block.
// No dependencies.
package otwo_pkg;

    typedef enum logic [4:0] {
        S_IDLE, S_VMUL, S_VSAT, S_DSTART,
        S_CINIT, S_CITER, S_CROUND,
        S_WMS, S_WMC, S_WACC, S_DXY,
        S_H0, S_H1, S_H2, S_H3, S_H4, S_H5,
        S_WDIV, S_K0, S_K1, S_K2, S_K3, S_K4, S_DONE
    } t_state;

    typedef logic [2:0] t_cfg_idx;

    localparam t_cfg_idx CFG_WHEEL_ANGLE_0      = 3'd0;
    localparam t_cfg_idx CFG_WHEEL_ANGLE_1      = 3'd1;
    localparam t_cfg_idx CFG_WHEEL_ANGLE_2      = 3'd2;
    localparam t_cfg_idx CFG_WHEEL_DISTANCE     = 3'd3;
    localparam t_cfg_idx CFG_METRES_PER_ROT     = 3'd4;
    localparam t_cfg_idx CFG_LOOP_RATE_HZ       = 3'd5;

    localparam logic signed [32:0] CORDIC_GAIN_Q30 = 33'sd652032874;
    localparam logic signed [32:0] RAD_TO_BAM_Q16  = 33'sd683565276;

    // restoring divider: 49-bit magnitude numerator
    localparam int DIV_STEPS = 49;
    localparam logic [5:0] DIV_LAST = 6'd48;

    // arctangent of 2^-i as a binary angle, 2^32 is one turn
    function automatic logic [29:0] atan_bam(input logic [4:0] i);
        logic [29:0] r;
        case (i)
            5'd0:  r = 30'd536870912;
            5'd1:  r = 30'd316933406;
            5'd2:  r = 30'd167458907;
            5'd3:  r = 30'd85004756;
            5'd4:  r = 30'd42667331;
            5'd5:  r = 30'd21354465;
            5'd6:  r = 30'd10679838;
            5'd7:  r = 30'd5340245;
            5'd8:  r = 30'd2670163;
            5'd9:  r = 30'd1335087;
            5'd10: r = 30'd667544;
            5'd11: r = 30'd333772;
            5'd12: r = 30'd166886;
            5'd13: r = 30'd83443;
            5'd14: r = 30'd41722;
            5'd15: r = 30'd20861;
            5'd16: r = 30'd10430;
            5'd17: r = 30'd5215;
            5'd18: r = 30'd2608;
            5'd19: r = 30'd1304;
            5'd20: r = 30'd652;
            5'd21: r = 30'd326;
            5'd22: r = 30'd163;
            5'd23: r = 30'd81;
            5'd24: r = 30'd41;
            5'd25: r = 30'd20;
            5'd26: r = 30'd10;
            5'd27: r = 30'd5;
            5'd28: r = 30'd3;
            5'd29: r = 30'd1;
            default: r = 30'd0;
        endcase
        return r;
    endfunction

    // clamp a wide signed value to signed 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
        logic signed [31:0] r;
        if (x > 66'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (x < -66'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

endpackage

// ===== src/otwo_in_if.sv =====
// Input channel of the omni odometry block: one beat of three wheel rotations.
// No dependencies.
interface otwo_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] rotation_0;
    logic signed [31:0] rotation_1;
    logic signed [31:0] rotation_2;

    modport source (output valid, output rotation_0, output rotation_1,
                    output rotation_2, input ready);
    modport sink   (input valid, input rotation_0, input rotation_1,
                    input rotation_2, output ready);
endinterface

// ===== src/otwo_out_if.sv =====
// Output channel of the omni odometry block: one beat of pose and velocities.
// No dependencies.
interface otwo_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pose_x;
    logic signed [31:0] pose_y;
    logic        [31:0] pose_heading;
    logic signed [31:0] velocity_x;
    logic signed [31:0] velocity_y;
    logic signed [31:0] velocity_turn;

    modport source (output valid, output pose_x, output pose_y, output pose_heading,
                    output velocity_x, output velocity_y, output velocity_turn,
                    input ready);
    modport sink   (input valid, input pose_x, input pose_y, input pose_heading,
                    input velocity_x, input velocity_y, input velocity_turn,
                    output ready);
endinterface

// ===== src/omni_three_wheel_odometry.sv =====
// Three-wheel omni odometry: sequencer, shared multiplier, CORDIC and divider.
// Depends on otwo_pkg, otwo_in_if, otwo_out_if and the assertion header.
//
// Usage:
//   i_in carries one beat of three signed Q16.16 wheel rotations per control
//   period. o_out returns one beat per input: world pose (x, y saturating,
//   heading wrapping) and robot-frame velocities. The config port writes one
//   register per cycle with i_cfg_we; write only while the block is idle.
//   i_in.ready is low while a beat is in flight and rises in the same cycle
//   as o_out.valid for that beat, so no new beat is accepted before the
//   last one has reached the output register. The CORDIC runs
//   four angles (three wheels, then the heading) one step a cycle, and the
//   33x33 multiplier is used for every product, one per cycle. The 49-step
//   divider for the turn runs alongside the CORDIC; S_WDIV waits while it
//   is still busy.
//   Reset clears the pose and loads the default registers.
//   A finished beat waits in the output register; the next beat is accepted
//   and computed meanwhile, and stalls only at its end if o_out is still full.
`include "omni_three_wheel_odometry_assert.svh"

module omni_three_wheel_odometry #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    otwo_in_if.sink             i_in,
    otwo_out_if.source          o_out,
    input  logic                i_cfg_we,
    input  otwo_pkg::t_cfg_idx  i_cfg_index,
    input  logic [31:0]         i_cfg_data
);

    localparam int CW = $clog2(CORDIC_STEPS);
    localparam logic [CW-1:0] LAST_STEP = CW'(CORDIC_STEPS - 1);

    // configuration
    logic [15:0] r_wa0, r_wa1, r_wa2, r_rate;
    logic [31:0] r_wdist, r_mpr;

    // sequencer
    otwo_pkg::t_state r_state, n_state;
    logic [1:0]       r_idx;

    // sample and intermediate values
    logic signed [31:0] r_rot [3];
    logic signed [31:0] r_v   [3];
    logic signed [33:0] r_sum;
    logic signed [51:0] r_sx, r_sy, r_t;
    logic signed [31:0] r_dx, r_dy, r_dw;
    logic signed [31:0] r_vx, r_vy, r_vw;

    // pose state
    logic signed [31:0] r_pos_x, r_pos_y;
    logic        [31:0] r_head;

    // CORDIC
    logic signed [32:0] r_cx, r_cy, r_cz;
    logic        [1:0]  r_quad;
    logic [CW-1:0]      r_cnt;
    logic signed [17:0] r_cos, r_sin;

    // shared multiplier
    logic signed [32:0] w_ma, w_mb;
    logic signed [65:0] w_prod, r_prod;

    // divider
    logic [33:0] r_drem, r_dden;
    logic [48:0] r_dquo;
    logic [5:0]  r_dcnt;
    logic        r_dbusy, r_dneg;

    // output register
    logic               r_ovalid;
    logic signed [31:0] r_o_px, r_o_py, r_o_vx, r_o_vy, r_o_vw;
    logic        [31:0] r_o_head;

    logic        w_accept, w_load;
    logic [31:0] w_ang, w_dist_nz;
    logic signed [32:0] w_xs, w_ys, w_atan, w_rx33, w_ry33;
    logic signed [17:0] w_rx, w_ry;
    logic signed [31:0] w_vsat;
    logic signed [33:0] w_sabs;
    logic [35:0] w_dtrial;
    logic signed [65:0] w_qs;

    assign w_accept = i_in.valid && i_in.ready;
    assign w_load   = (r_state == otwo_pkg::S_DONE) && (!r_ovalid || o_out.ready);

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wa0   <= 16'd0;
            r_wa1   <= 16'd21845;
            r_wa2   <= 16'd43690;
            r_wdist <= 32'd13107;
            r_mpr   <= 32'd65536;
            r_rate  <= 16'd100;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                otwo_pkg::CFG_WHEEL_ANGLE_0:  r_wa0   <= i_cfg_data[15:0];
                otwo_pkg::CFG_WHEEL_ANGLE_1:  r_wa1   <= i_cfg_data[15:0];
                otwo_pkg::CFG_WHEEL_ANGLE_2:  r_wa2   <= i_cfg_data[15:0];
                otwo_pkg::CFG_WHEEL_DISTANCE: r_wdist <= i_cfg_data;
                otwo_pkg::CFG_METRES_PER_ROT: r_mpr   <= i_cfg_data;
                otwo_pkg::CFG_LOOP_RATE_HZ:   r_rate  <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            otwo_pkg::S_IDLE:   if (w_accept) n_state = otwo_pkg::S_VMUL;
            otwo_pkg::S_VMUL:   n_state = otwo_pkg::S_VSAT;
            otwo_pkg::S_VSAT:   n_state = (r_idx == 2'd2) ? otwo_pkg::S_DSTART
                                                          : otwo_pkg::S_VMUL;
            otwo_pkg::S_DSTART: n_state = otwo_pkg::S_CINIT;
            otwo_pkg::S_CINIT:  n_state = otwo_pkg::S_CITER;
            otwo_pkg::S_CITER:  if (r_cnt == LAST_STEP) n_state = otwo_pkg::S_CROUND;
            otwo_pkg::S_CROUND: n_state = (r_idx == 2'd3) ? otwo_pkg::S_H0
                                                          : otwo_pkg::S_WMS;
            otwo_pkg::S_WMS:    n_state = otwo_pkg::S_WMC;
            otwo_pkg::S_WMC:    n_state = otwo_pkg::S_WACC;
            otwo_pkg::S_WACC:   n_state = (r_idx == 2'd2) ? otwo_pkg::S_DXY
                                                          : otwo_pkg::S_CINIT;
            otwo_pkg::S_DXY:    n_state = otwo_pkg::S_CINIT;
            otwo_pkg::S_H0:     n_state = otwo_pkg::S_H1;
            otwo_pkg::S_H1:     n_state = otwo_pkg::S_H2;
            otwo_pkg::S_H2:     n_state = otwo_pkg::S_H3;
            otwo_pkg::S_H3:     n_state = otwo_pkg::S_H4;
            otwo_pkg::S_H4:     n_state = otwo_pkg::S_H5;
            otwo_pkg::S_H5:     n_state = otwo_pkg::S_WDIV;
            otwo_pkg::S_WDIV:   if (!r_dbusy) n_state = otwo_pkg::S_K0;
            otwo_pkg::S_K0:     n_state = otwo_pkg::S_K1;
            otwo_pkg::S_K1:     n_state = otwo_pkg::S_K2;
            otwo_pkg::S_K2:     n_state = otwo_pkg::S_K3;
            otwo_pkg::S_K3:     n_state = otwo_pkg::S_K4;
            otwo_pkg::S_K4:     n_state = otwo_pkg::S_DONE;
            otwo_pkg::S_DONE:   if (w_load) n_state = otwo_pkg::S_IDLE;
            default:            n_state = otwo_pkg::S_IDLE;
        endcase
    end

    // ---------------- outputs: handshake and multiplier operands ----------------
    always_comb begin
        i_in.ready = (r_state == otwo_pkg::S_IDLE) && i_rst_n;
        w_ma = '0;
        w_mb = '0;
        case (r_state)
            otwo_pkg::S_VMUL: begin
                w_ma = 33'(r_rot[r_idx]);
                w_mb = signed'({1'b0, r_mpr});
            end
            otwo_pkg::S_WMS: begin w_ma = 33'(r_sin); w_mb = 33'(r_v[r_idx]); end
            otwo_pkg::S_WMC: begin w_ma = 33'(r_cos); w_mb = 33'(r_v[r_idx]); end
            otwo_pkg::S_H0:  begin w_ma = 33'(r_cos); w_mb = 33'(r_dx); end
            otwo_pkg::S_H1:  begin w_ma = 33'(r_sin); w_mb = 33'(r_dy); end
            otwo_pkg::S_H2:  begin w_ma = 33'(r_sin); w_mb = 33'(r_dx); end
            otwo_pkg::S_H3:  begin w_ma = 33'(r_cos); w_mb = 33'(r_dy); end
            otwo_pkg::S_K0:  begin w_ma = 33'(r_dx); w_mb = signed'({17'b0, r_rate}); end
            otwo_pkg::S_K1:  begin w_ma = 33'(r_dy); w_mb = signed'({17'b0, r_rate}); end
            otwo_pkg::S_K2:  begin w_ma = 33'(r_dw); w_mb = otwo_pkg::RAD_TO_BAM_Q16; end
            otwo_pkg::S_K3:  begin w_ma = 33'(r_dw); w_mb = signed'({17'b0, r_rate}); end
            default: ;
        endcase
    end

    assign w_prod = w_ma * w_mb;

    // ---------------- datapath helpers ----------------
    always_comb begin
        case (r_idx)
            2'd0:    w_ang = {r_wa0, 16'b0};
            2'd1:    w_ang = {r_wa1, 16'b0};
            2'd2:    w_ang = {r_wa2, 16'b0};
            default: w_ang = r_head;
        endcase
    end

    assign w_xs   = r_cx >>> r_cnt;
    assign w_ys   = r_cy >>> r_cnt;
    assign w_atan = signed'({3'b0, otwo_pkg::atan_bam(5'(r_cnt))});
    assign w_rx33 = (r_cx + 33'sd8192) >>> 14;
    assign w_ry33 = (r_cy + 33'sd8192) >>> 14;
    assign w_rx   = w_rx33[17:0];
    assign w_ry   = w_ry33[17:0];

    assign w_vsat    = otwo_pkg::sat32(r_prod >>> 16);
    assign w_dist_nz = (r_wdist == 32'd0) ? 32'd1 : r_wdist;
    assign w_sabs    = r_sum[33] ? -r_sum : r_sum;
    assign w_dtrial  = {1'b0, r_drem, r_dquo[48]} - {2'b0, r_dden};
    assign w_qs      = r_dneg ? -signed'({17'b0, r_dquo}) : signed'({17'b0, r_dquo});

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= otwo_pkg::S_IDLE;
            r_idx    <= 2'd0;
            r_cnt    <= '0;
            r_dbusy  <= 1'b0;
            r_dcnt   <= 6'd0;
            r_ovalid <= 1'b0;
            r_pos_x  <= '0;
            r_pos_y  <= '0;
            r_head   <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                otwo_pkg::S_IDLE:   if (w_accept) r_idx <= 2'd0;
                otwo_pkg::S_VSAT:   r_idx <= r_idx + 2'd1;
                otwo_pkg::S_DSTART: r_idx <= 2'd0;
                otwo_pkg::S_CINIT:  r_cnt <= '0;
                otwo_pkg::S_CITER:  r_cnt <= r_cnt + 1'b1;
                otwo_pkg::S_WACC:   r_idx <= r_idx + 2'd1;
                otwo_pkg::S_H3:
                    r_pos_x <= otwo_pkg::sat32(66'(r_pos_x) + 66'(r_t >>> 16));
                otwo_pkg::S_H5:
                    r_pos_y <= otwo_pkg::sat32(66'(r_pos_y) + 66'(r_t >>> 16));
                otwo_pkg::S_K3:     r_head <= r_head + r_prod[47:16];
                default: ;
            endcase

            // divider sequencing
            if (r_state == otwo_pkg::S_DSTART) begin
                r_dbusy <= 1'b1;
                r_dcnt  <= 6'd0;
            end else if (r_dbusy) begin
                r_dcnt <= r_dcnt + 6'd1;
                if (r_dcnt == otwo_pkg::DIV_LAST) r_dbusy <= 1'b0;
            end

            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        case (r_state)
            otwo_pkg::S_IDLE: begin
                if (w_accept) begin
                    r_rot[0] <= i_in.rotation_0;
                    r_rot[1] <= i_in.rotation_1;
                    r_rot[2] <= i_in.rotation_2;
                    r_sum    <= '0;
                    r_sx     <= '0;
                    r_sy     <= '0;
                end
            end
            otwo_pkg::S_VSAT: begin
                r_v[r_idx] <= w_vsat;
                r_sum      <= r_sum + 34'(w_vsat);
            end
            otwo_pkg::S_DSTART: begin
                r_dneg <= r_sum[33];
                r_dquo <= {w_sabs[32:0], 16'b0};
                r_drem <= '0;
                r_dden <= ({2'b0, w_dist_nz} << 1) + {2'b0, w_dist_nz};
            end
            otwo_pkg::S_CINIT: begin
                r_quad <= w_ang[31:30];
                r_cz   <= signed'({3'b0, w_ang[29:0]});
                r_cx   <= otwo_pkg::CORDIC_GAIN_Q30;
                r_cy   <= '0;
            end
            otwo_pkg::S_CITER: begin
                if (!r_cz[32]) begin
                    r_cx <= r_cx - w_ys;
                    r_cy <= r_cy + w_xs;
                    r_cz <= r_cz - w_atan;
                end else begin
                    r_cx <= r_cx + w_ys;
                    r_cy <= r_cy - w_xs;
                    r_cz <= r_cz + w_atan;
                end
            end
            otwo_pkg::S_CROUND: begin
                // fold the quadrant back in
                case (r_quad)
                    2'd0:    begin r_cos <= w_rx;  r_sin <= w_ry;  end
                    2'd1:    begin r_cos <= -w_ry; r_sin <= w_rx;  end
                    2'd2:    begin r_cos <= -w_rx; r_sin <= -w_ry; end
                    default: begin r_cos <= w_ry;  r_sin <= -w_rx; end
                endcase
            end
            otwo_pkg::S_WMC:  r_sx <= r_sx + r_prod[51:0];
            otwo_pkg::S_WACC: r_sy <= r_sy + r_prod[51:0];
            otwo_pkg::S_DXY: begin
                r_dx <= otwo_pkg::sat32((66'sd0 - 66'(r_sx)) >>> 16);
                r_dy <= otwo_pkg::sat32(66'(r_sy) >>> 16);
            end
            otwo_pkg::S_H1: r_t <= r_prod[51:0];
            otwo_pkg::S_H2: r_t <= r_t - r_prod[51:0];
            otwo_pkg::S_H3: r_t <= r_prod[51:0];
            otwo_pkg::S_H4: r_t <= r_t + r_prod[51:0];
            otwo_pkg::S_WDIV: if (!r_dbusy) r_dw <= otwo_pkg::sat32(w_qs);
            otwo_pkg::S_K1: r_vx <= otwo_pkg::sat32(r_prod);
            otwo_pkg::S_K2: r_vy <= otwo_pkg::sat32(r_prod);
            otwo_pkg::S_K4: r_vw <= otwo_pkg::sat32(r_prod);
            default: ;
        endcase

        // one restoring step a cycle
        if (r_dbusy) begin
            if (!w_dtrial[35]) r_drem <= w_dtrial[33:0];
            else               r_drem <= {r_drem[32:0], r_dquo[48]};
            r_dquo <= {r_dquo[47:0], ~w_dtrial[35]};
        end

        if (w_load) begin
            r_o_px   <= r_pos_x;
            r_o_py   <= r_pos_y;
            r_o_head <= r_head;
            r_o_vx   <= r_vx;
            r_o_vy   <= r_vy;
            r_o_vw   <= r_vw;
        end
    end

    assign o_out.valid         = r_ovalid;
    assign o_out.pose_x        = r_o_px;
    assign o_out.pose_y        = r_o_py;
    assign o_out.pose_heading  = r_o_head;
    assign o_out.velocity_x    = r_o_vx;
    assign o_out.velocity_y    = r_o_vy;
    assign o_out.velocity_turn = r_o_vw;

    // ---------------- checks ----------------
    `OTWO_ASSERT_NXT(a_busy_after_beat, i_clk, i_rst_n, w_accept, !i_in.ready)
    `OTWO_ASSERT_IMP(a_cordic_count, i_clk, i_rst_n, r_state == otwo_pkg::S_CITER, r_cnt <= LAST_STEP)
    `OTWO_ASSERT_NXT(a_heading_hold, i_clk, i_rst_n, r_state != otwo_pkg::S_K3, $stable(r_head))
    `OTWO_ASSERT_IMP(a_div_done_late, i_clk, i_rst_n, r_state == otwo_pkg::S_K0, !r_dbusy)

endmodule

// ===== sim/omni_three_wheel_odometry_tb.sv =====
// Testbench for the three-wheel omni odometry block: random and directed wheel beats,
// with the pose predicted in a scoreboard class. Depends on otwo_pkg, the channel interfaces and the DUT.
`timescale 1ns / 100ps

module omni_three_wheel_odometry_tb;

    localparam int                 CYCLE_LIMIT  = 2000000;
    localparam int                 DRAIN_CYCLES = 120;
    localparam otwo_pkg::t_cfg_idx CFG_SPARE_6  = 3'd6;
    localparam otwo_pkg::t_cfg_idx CFG_SPARE_7  = 3'd7;

    typedef struct packed {
        logic [31:0] pose_x;
        logic [31:0] pose_y;
        logic [31:0] pose_heading;
        logic [31:0] velocity_x;
        logic [31:0] velocity_y;
        logic [31:0] velocity_turn;
    } t_pose_beat;

    class odometry_scoreboard;
        logic [15:0]  wheel_ang [3];
        logic [31:0]  distance;
        logic [31:0]  metres_per_rot;
        logic [15:0]  rate_hz;
        longint       pos_x;
        longint       pos_y;
        logic [31:0]  heading;
        t_pose_beat   pending [$];
        int           errors;
        longint       arctan [16];

        function new();
            arctan = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                       10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
                       83443, 41722, 20861};
            errors = 0;
            wheel_ang[0] = 16'd0;
            wheel_ang[1] = 16'd21845;
            wheel_ang[2] = 16'd43690;
            distance = 32'd13107;
            metres_per_rot = 32'd65536;
            rate_hz = 16'd100;
            pos_x = 0;
            pos_y = 0;
            heading = '0;
        endfunction

        function void write_reg(otwo_pkg::t_cfg_idx idx, logic [31:0] data);
            case (idx)
                otwo_pkg::CFG_WHEEL_ANGLE_0:  wheel_ang[0] = data[15:0];
                otwo_pkg::CFG_WHEEL_ANGLE_1:  wheel_ang[1] = data[15:0];
                otwo_pkg::CFG_WHEEL_ANGLE_2:  wheel_ang[2] = data[15:0];
                otwo_pkg::CFG_WHEEL_DISTANCE: distance = data;
                otwo_pkg::CFG_METRES_PER_ROT: metres_per_rot = data;
                otwo_pkg::CFG_LOOP_RATE_HZ:   rate_hz = data[15:0];
                default: ;
            endcase
        endfunction

        function longint clamp32(longint x);
            if (x > 64'sd2147483647) return 64'sd2147483647;
            if (x < -64'sd2147483648) return -64'sd2147483648;
            return x;
        endfunction

        // cos and sin in Q16.16 of a 32-bit binary angle
        function void cos_sin(logic [31:0] ang, output longint c, output longint s);
            longint x, y, z, xs, ys;
            x = 652032874;
            y = 0;
            z = longint'(ang[29:0]);
            for (int i = 0; i < 16; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (z >= 0) begin
                    x -= ys; y += xs; z -= arctan[i];
                end else begin
                    x += ys; y -= xs; z += arctan[i];
                end
            end
            x = (x + 8192) >>> 14;
            y = (y + 8192) >>> 14;
            case (ang[31:30])
                2'd0: begin c = x;  s = y;  end
                2'd1: begin c = -y; s = x;  end
                2'd2: begin c = -x; s = -y; end
                default: begin c = y; s = -x; end
            endcase
        endfunction

        function void note_input(logic signed [31:0] r0, logic signed [31:0] r1,
                                 logic signed [31:0] r2);
            logic signed [31:0] rot [3];
            longint v, c, s, sx, sy, sum, dx, dy, dw, ch, sh, den, dang;
            t_pose_beat e;
            rot = '{r0, r1, r2};
            sx = 0; sy = 0; sum = 0;
            for (int i = 0; i < 3; i++) begin
                v = clamp32((longint'(rot[i]) * longint'(metres_per_rot)) >>> 16);
                cos_sin({wheel_ang[i], 16'h0}, c, s);
                sx += s * v;
                sy += c * v;
                sum += v;
            end
            dx = clamp32((-sx) >>> 16);
            dy = clamp32(sy >>> 16);
            den = 3 * ((distance == 0) ? 64'sd1 : longint'(distance));
            dw = clamp32((sum * 65536) / den);
            // rotate by the heading held before this beat
            cos_sin(heading, ch, sh);
            pos_x = clamp32(pos_x + ((ch * dx - sh * dy) >>> 16));
            pos_y = clamp32(pos_y + ((sh * dx + ch * dy) >>> 16));
            dang = (dw * 683565276) >>> 16;
            heading = heading + dang[31:0];
            e.pose_x = pos_x[31:0];
            e.pose_y = pos_y[31:0];
            e.pose_heading = heading;
            e.velocity_x = 32'(clamp32(dx * longint'(rate_hz)));
            e.velocity_y = 32'(clamp32(dy * longint'(rate_hz)));
            e.velocity_turn = 32'(clamp32(dw * longint'(rate_hz)));
            pending.push_back(e);
        endfunction

        function void check_result(t_pose_beat got);
            t_pose_beat e;
            if (pending.size() == 0) begin
                $error("result beat with nothing pending");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.pose_x !== e.pose_x) begin
                $error("pose_x expected %h actual %h", e.pose_x, got.pose_x); errors++;
            end
            if (got.pose_y !== e.pose_y) begin
                $error("pose_y expected %h actual %h", e.pose_y, got.pose_y); errors++;
            end
            if (got.pose_heading !== e.pose_heading) begin
                $error("pose_heading expected %h actual %h", e.pose_heading,
                       got.pose_heading);
                errors++;
            end
            if (got.velocity_x !== e.velocity_x) begin
                $error("velocity_x expected %h actual %h", e.velocity_x, got.velocity_x);
                errors++;
            end
            if (got.velocity_y !== e.velocity_y) begin
                $error("velocity_y expected %h actual %h", e.velocity_y, got.velocity_y);
                errors++;
            end
            if (got.velocity_turn !== e.velocity_turn) begin
                $error("velocity_turn expected %h actual %h", e.velocity_turn,
                       got.velocity_turn);
                errors++;
            end
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                cfg_we;
    otwo_pkg::t_cfg_idx  cfg_index;
    logic [31:0]         cfg_data;
    int                  cycles;
    int                  beats_out;

    otwo_in_if  in_ch ();
    otwo_out_if out_ch ();

    odometry_scoreboard pose_board;

    omni_three_wheel_odometry DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        i_clk = 1'b1; #4;
        i_clk = 1'b0; #4;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // hold one write per edge; caller drops the enable after a batch
    task automatic write_cfg(otwo_pkg::t_cfg_idx idx, logic [31:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        pose_board.write_reg(idx, data);
    endtask

    task automatic end_cfg();
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_beat(logic signed [31:0] r0, logic signed [31:0] r1,
                             logic signed [31:0] r2);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.rotation_0 <= r0;
        in_ch.rotation_1 <= r1;
        in_ch.rotation_2 <= r2;
        do @(posedge i_clk); while (!(in_ch.valid && in_ch.ready));
        pose_board.note_input(r0, r1, r2);
    endtask

    function automatic logic [31:0] rand_rotation();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 6) return 32'($urandom_range(0, 262144)) - 32'd131072;
        if (pick < 8) return 32'($urandom_range(0, 33554432)) - 32'd16777216;
        return $urandom;
    endfunction

    // drop valid, drain every pending beat, then let the block settle
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (pose_board.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic random_beats(int n);
        for (int k = 0; k < n; k++) begin
            send_beat(rand_rotation(), rand_rotation(), rand_rotation());
        end
        wait_idle();
    endtask

    // receiver: random stalls, one long hold-off to back up the input
    initial begin
        int gap;
        out_ch.ready = 1'b0;
        beats_out = 0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
            if (beats_out == 150) gap = 900;
            if (gap > 0) begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(out_ch.valid && out_ch.ready));
            pose_board.check_result({out_ch.pose_x, out_ch.pose_y, out_ch.pose_heading,
                                     out_ch.velocity_x, out_ch.velocity_y,
                                     out_ch.velocity_turn});
            beats_out++;
        end
    end

    initial begin
        pose_board = new();
        i_rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = otwo_pkg::CFG_WHEEL_ANGLE_0;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.rotation_0 = '0;
        in_ch.rotation_1 = '0;
        in_ch.rotation_2 = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // defaults: field extremes
        send_beat(32'sd0, 32'sd0, 32'sd0);
        send_beat(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
        send_beat(32'sh80000000, 32'sh80000000, 32'sh80000000);
        send_beat(32'sh7fffffff, 32'sh80000000, 32'sd0);
        send_beat(32'sd65536, 32'sd0, 32'sd0);
        send_beat(32'sd0, -32'sd65536, 32'sd65536);
        send_beat(32'sd65536, 32'sd65536, 32'sd65536);
        send_beat(-32'sd1, -32'sd1, -32'sd1);
        send_beat(32'sd1, 32'sd1, 32'sd1);
        send_beat(32'shffffffff, 32'h55555555, 32'haaaaaaaa);
        random_beats(300);

        // angle extremes, smallest distance, highest rate
        write_cfg(otwo_pkg::CFG_WHEEL_ANGLE_0, 32'd65535);
        write_cfg(otwo_pkg::CFG_WHEEL_ANGLE_1, 32'd0);
        write_cfg(otwo_pkg::CFG_WHEEL_ANGLE_2, 32'd32768);
        write_cfg(otwo_pkg::CFG_WHEEL_DISTANCE, 32'd1);
        write_cfg(otwo_pkg::CFG_LOOP_RATE_HZ, 32'd65535);
        end_cfg();
        send_beat(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
        send_beat(32'sh80000000, 32'sd0, 32'sh7fffffff);
        random_beats(150);

        // zero distance, zero travel, zero rate
        write_cfg(otwo_pkg::CFG_WHEEL_DISTANCE, 32'd0);
        write_cfg(otwo_pkg::CFG_METRES_PER_ROT, 32'd0);
        write_cfg(otwo_pkg::CFG_LOOP_RATE_HZ, 32'd0);
        end_cfg();
        send_beat(32'sh7fffffff, 32'sh80000000, 32'sd12345);
        random_beats(100);

        // largest distance and travel, unit rate
        write_cfg(otwo_pkg::CFG_WHEEL_DISTANCE, 32'hffffffff);
        write_cfg(otwo_pkg::CFG_METRES_PER_ROT, 32'hffffffff);
        write_cfg(otwo_pkg::CFG_LOOP_RATE_HZ, 32'd1);
        end_cfg();
        send_beat(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
        send_beat(32'sh80000000, 32'sh80000000, 32'sh80000000);
        random_beats(150);

        // smallest travel; writes past the list must not land
        write_cfg(otwo_pkg::CFG_METRES_PER_ROT, 32'd1);
        write_cfg(otwo_pkg::CFG_WHEEL_DISTANCE, 32'd13107);
        write_cfg(CFG_SPARE_6, 32'hffffffff);
        write_cfg(CFG_SPARE_7, 32'h00000000);
        end_cfg();
        random_beats(100);

        for (int p = 0; p < 8; p++) begin
            write_cfg(otwo_pkg::CFG_WHEEL_ANGLE_0, $urandom_range(0, 65535));
            write_cfg(otwo_pkg::CFG_WHEEL_ANGLE_1, $urandom_range(0, 65535));
            write_cfg(otwo_pkg::CFG_WHEEL_ANGLE_2, $urandom_range(0, 65535));
            write_cfg(otwo_pkg::CFG_WHEEL_DISTANCE,
                      ($urandom_range(0, 1) == 0) ? $urandom_range(1, 262144) : $urandom);
            write_cfg(otwo_pkg::CFG_METRES_PER_ROT,
                      ($urandom_range(0, 1) == 0) ? $urandom_range(1, 262144) : $urandom);
            write_cfg(otwo_pkg::CFG_LOOP_RATE_HZ, $urandom_range(0, 65535));
            end_cfg();
            random_beats(137);
        end

        if (pose_board.errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+src
src/otwo_pkg.sv
src/otwo_in_if.sv
src/otwo_out_if.sv
src/omni_three_wheel_odometry.sv
sim/omni_three_wheel_odometry_tb.sv
